### rtl/ssc_pkg.sv
// Shared types, widths and the helper function of the sphere contact pipeline.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ssc_pkg;

  // Field and datapath widths.
  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW   = 31;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned SumW   = 66;
  localparam int unsigned RootW  = 33;
  localparam int unsigned QuoW   = 30;
  localparam int unsigned HalfW  = 6;

  // Values that travel alongside the length computation.
  typedef struct packed {
    logic [2:0][CoordW-1:0] c1;
    logic [2:0][DiffW-1:0]  mag;
    logic [2:0]             neg;
    logic [RadW-1:0]        r1;
    logic [CoordW-1:0]      rsum;
  } side_t;

  // One slot of the square-root pipeline.
  typedef struct packed {
    side_t             side;
    logic [SumW-1:0]   rem;
    logic [RootW-1:0]  root;
    logic [HalfW-1:0]  hb;
  } sq_t;

  // One slot of the normal division pipeline.
  typedef struct packed {
    side_t                 side;
    logic [RootW-1:0]      len;
    logic                  hit;
    logic [2:0]            sat;
    logic [2:0][DiffW-1:0] rem;
    logic [2:0][QuoW-1:0]  quo;
  } dv_t;

  // Half the index of the leading one of the squared length; zero for zero.
  function automatic logic [HalfW-1:0] half_msb(logic [SumW-1:0] s);
    logic [HalfW:0] m;
    m = '0;
    for (int b = 0; b < SumW; b++) begin
      if (s[b]) begin
        m = (HalfW+1)'(b);
      end
    end
    return m[HalfW:1];
  endfunction

endpackage

`default_nettype wire

### rtl/ssc_front.sv
// Front end: centre difference, magnitudes, squares, squared length, root start bit.
// Depends on ssc_pkg.
`default_nettype none

module ssc_front import ssc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              valid_i,
  input  wire logic [CoordW-1:0] first_x_i,
  input  wire logic [CoordW-1:0] first_y_i,
  input  wire logic [CoordW-1:0] first_z_i,
  input  wire logic [RadW-1:0]   first_radius_i,
  input  wire logic [CoordW-1:0] second_x_i,
  input  wire logic [CoordW-1:0] second_y_i,
  input  wire logic [CoordW-1:0] second_z_i,
  input  wire logic [RadW-1:0]   second_radius_i,
  output logic                   valid_o,
  output sq_t                    out_o
);

  logic [4:0] v_q;

  logic [2:0][DiffW-1:0]  d0_d, d0_q;
  logic [2:0][CoordW-1:0] c1_0_q;
  logic [RadW-1:0]        r1_0_q;
  logic [CoordW-1:0]      rsum0_d, rsum0_q;
  side_t                  side1_d, side1_q, side2_q, side3_q;
  logic [2:0][SumW-1:0]   sqr2_d, sqr2_q;
  logic [SumW-1:0]        sum3_d, sum3_q;
  sq_t                    out_d, out_q;

  // Stage 0: signed differences and the radius sum.
  always_comb begin
    d0_d[0] = {first_x_i[CoordW-1], first_x_i} - {second_x_i[CoordW-1], second_x_i};
    d0_d[1] = {first_y_i[CoordW-1], first_y_i} - {second_y_i[CoordW-1], second_y_i};
    d0_d[2] = {first_z_i[CoordW-1], first_z_i} - {second_z_i[CoordW-1], second_z_i};
    rsum0_d = {1'b0, first_radius_i} + {1'b0, second_radius_i};
  end

  // Stage 1: magnitudes and signs.
  always_comb begin
    side1_d.c1   = c1_0_q;
    side1_d.r1   = r1_0_q;
    side1_d.rsum = rsum0_q;
    for (int i = 0; i < 3; i++) begin
      side1_d.neg[i] = d0_q[i][DiffW-1];
      side1_d.mag[i] = d0_q[i][DiffW-1] ? (~d0_q[i] + DiffW'(1)) : d0_q[i];
    end
  end

  // Stage 2: one squarer per axis.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqr2_d[i] = SumW'(side1_q.mag[i]) * SumW'(side1_q.mag[i]);
    end
  end

  // Stage 3: squared length.
  assign sum3_d = sqr2_q[0] + sqr2_q[1] + sqr2_q[2];

  // Stage 4: start bit of the root and the initial remainder.
  always_comb begin
    out_d.side = side3_q;
    out_d.rem  = sum3_q;
    out_d.root = '0;
    out_d.hb   = half_msb(sum3_q);
  end

  // Valid bits advance with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d0_q    <= d0_d;
      c1_0_q  <= {first_z_i, first_y_i, first_x_i};
      r1_0_q  <= first_radius_i;
      rsum0_q <= rsum0_d;
      side1_q <= side1_d;
      side2_q <= side1_q;
      sqr2_q  <= sqr2_d;
      side3_q <= side2_q;
      sum3_q  <= sum3_d;
      out_q   <= out_d;
    end
  end

  assign valid_o = v_q[4];
  assign out_o   = out_q;

endmodule

`default_nettype wire

### rtl/ssc_sqrt_stage.sv
// One stage of the square-root pipeline: decides a single root bit.
// Depends on ssc_pkg.
`default_nettype none

module ssc_sqrt_stage import ssc_pkg::*; #(
  parameter int unsigned BIT   = 0,
  parameter int unsigned STEPS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire logic valid_i,
  input  sq_t       in_i,
  output logic      valid_o,
  output sq_t       out_o
);

  localparam int unsigned Lim = BIT + STEPS;

  logic [SumW:0] trial;
  logic          en;
  logic          take;
  sq_t           out_d, out_q;
  logic          v_q;

  // Growth of the square when this bit is set: 2*r*2^k + 2^2k.
  always_comb begin
    trial = ((SumW+1)'(in_i.root) << (BIT + 1)) + ((SumW+1)'(1) << (2 * BIT));
    en    = 32'(in_i.hb) < Lim;
    take  = en && (trial <= {1'b0, in_i.rem});
    out_d = in_i;
    if (take) begin
      out_d.rem  = in_i.rem - trial[SumW-1:0];
      out_d.root = in_i.root | (RootW'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = v_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire

### rtl/ssc_div_stage.sv
// One stage of the three normal dividers: one quotient bit per axis.
// Depends on ssc_pkg.
`default_nettype none

module ssc_div_stage import ssc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire logic valid_i,
  input  dv_t       in_i,
  output logic      valid_o,
  output dv_t       out_o
);

  logic [DiffW:0] twice;
  logic           ge;
  dv_t            out_d, out_q;
  logic           v_q;

  // Restoring division step; the remainder stays below the length once it starts below it.
  always_comb begin
    out_d = in_i;
    twice = '0;
    ge    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      twice = {in_i.rem[i], 1'b0};
      ge    = twice >= {1'b0, in_i.len};
      out_d.rem[i] = ge ? DiffW'(twice - {1'b0, in_i.len}) : twice[DiffW-1:0];
      out_d.quo[i] = {in_i.quo[i][QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = v_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire

### rtl/sphere_sphere_contact.sv
// Sphere against sphere contact test, fully pipelined: a new request may enter on
// every unstalled clock and each one yields one result after 5 front-end stages,
// one stage per root bit for 33 root bits, one setup stage, 30 divider stages,
// one multiply stage and the output register. A stall from downstream freezes the
// whole pipeline, so no request is lost; stall_o follows stall_i while a result waits.
`default_nettype none

module sphere_sphere_contact import ssc_pkg::*; #(
  parameter int unsigned SQRT_STEPS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire logic [CoordW-1:0] first_x_i,
  input  wire logic [CoordW-1:0] first_y_i,
  input  wire logic [CoordW-1:0] first_z_i,
  input  wire logic [RadW-1:0]   first_radius_i,
  input  wire logic [CoordW-1:0] second_x_i,
  input  wire logic [CoordW-1:0] second_y_i,
  input  wire logic [CoordW-1:0] second_z_i,
  input  wire logic [RadW-1:0]   second_radius_i,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output logic                   hit_o,
  output logic [CoordW-1:0]      normal_x_o,
  output logic [CoordW-1:0]      normal_y_o,
  output logic [CoordW-1:0]      normal_z_o,
  output logic [CoordW-1:0]      contact_x_o,
  output logic [CoordW-1:0]      contact_y_o,
  output logic [CoordW-1:0]      contact_z_o,
  output logic [CoordW-1:0]      depth_o
);

  localparam logic [QuoW:0] OneQ30 = (QuoW+1)'(1) << QuoW;

  typedef struct packed {
    logic [2:0][CoordW-1:0] c1;
    logic [2:0][CoordW-1:0] nrm;
    logic [2:0][CoordW-1:0] off;
    logic [2:0]             neg;
    logic                   hit;
    logic [CoordW-1:0]      depth;
  } mul_t;

  logic adv;
  logic out_v_q;

  // The pipeline moves unless a finished result is held by the receiver.
  assign adv     = !(out_v_q && stall_i);
  assign stall_o = !adv;

  // Front end.
  logic sq_v   [0:RootW];
  sq_t  sq_pipe[0:RootW];

  ssc_front u_front (
    .clk_i,
    .rst_ni,
    .adv_i           (adv),
    .valid_i,
    .first_x_i,
    .first_y_i,
    .first_z_i,
    .first_radius_i,
    .second_x_i,
    .second_y_i,
    .second_z_i,
    .second_radius_i,
    .valid_o         (sq_v[0]),
    .out_o           (sq_pipe[0])
  );

  // Square root, most significant bit first.
  for (genvar g = 0; g < RootW; g++) begin : g_sqrt
    ssc_sqrt_stage #(
      .BIT   (RootW - 1 - g),
      .STEPS (SQRT_STEPS)
    ) u_stage (
      .clk_i,
      .rst_ni,
      .adv_i   (adv),
      .valid_i (sq_v[g]),
      .in_i    (sq_pipe[g]),
      .valid_o (sq_v[g+1]),
      .out_o   (sq_pipe[g+1])
    );
  end

  // Setup: hit decision, clamp detection and divider start.
  logic dv_v   [0:QuoW];
  dv_t  dv_pipe[0:QuoW];
  dv_t  dv0_d, dv0_q;
  logic dv0_v_q;

  always_comb begin
    dv0_d.side = sq_pipe[RootW].side;
    dv0_d.len  = sq_pipe[RootW].root;
    dv0_d.hit  = sq_pipe[RootW].root < {1'b0, sq_pipe[RootW].side.rsum};
    dv0_d.rem  = sq_pipe[RootW].side.mag;
    dv0_d.quo  = '0;
    for (int i = 0; i < 3; i++) begin
      dv0_d.sat[i] = sq_pipe[RootW].side.mag[i] >= sq_pipe[RootW].root;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv0_v_q <= 1'b0;
    end else if (adv) begin
      dv0_v_q <= sq_v[RootW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv0_q <= dv0_d;
    end
  end

  assign dv_v[0]    = dv0_v_q;
  assign dv_pipe[0] = dv0_q;

  // Normal division, one quotient bit per stage.
  for (genvar g = 0; g < QuoW; g++) begin : g_div
    ssc_div_stage u_stage (
      .clk_i,
      .rst_ni,
      .adv_i   (adv),
      .valid_i (dv_v[g]),
      .in_i    (dv_pipe[g]),
      .valid_o (dv_v[g+1]),
      .out_o   (dv_pipe[g+1])
    );
  end

  // Multiply stage: clamp the quotient, sign the normal and scale by the radius.
  dv_t            dv_last;
  logic [QuoW:0]  q;
  logic [61:0]    prod;
  mul_t           mul_d, mul_q;
  logic           mul_v_q;

  assign dv_last = dv_pipe[QuoW];

  always_comb begin
    mul_d.c1    = dv_last.side.c1;
    mul_d.neg   = dv_last.side.neg;
    mul_d.hit   = dv_last.hit;
    mul_d.depth = dv_last.side.rsum - dv_last.len[CoordW-1:0];
    q    = '0;
    prod = '0;
    for (int i = 0; i < 3; i++) begin
      if (dv_last.len == '0) begin
        q = '0;
      end else if (dv_last.sat[i]) begin
        q = OneQ30;
      end else begin
        q = {1'b0, dv_last.quo[i]};
      end
      prod         = 62'(q) * 62'(dv_last.side.r1);
      mul_d.off[i] = prod[61:30];
      mul_d.nrm[i] = dv_last.side.neg[i] ? (~CoordW'(q) + CoordW'(1)) : CoordW'(q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else if (adv) begin
      mul_v_q <= dv_v[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_q <= mul_d;
    end
  end

  // Output register: contact point with saturation, zeroed fields on a miss.
  logic signed [CoordW+1:0]  csum;
  logic [2:0][CoordW-1:0]    cont_d, cont_q, nrm_d, nrm_q;
  logic [CoordW-1:0]         depth_d, depth_q;
  logic                      hit_q;

  always_comb begin
    csum = '0;
    for (int i = 0; i < 3; i++) begin
      if (mul_q.neg[i]) begin
        csum = $signed({{2{mul_q.c1[i][CoordW-1]}}, mul_q.c1[i]})
             + $signed({2'b00, mul_q.off[i]});
      end else begin
        csum = $signed({{2{mul_q.c1[i][CoordW-1]}}, mul_q.c1[i]})
             - $signed({2'b00, mul_q.off[i]});
      end
      if (csum > $signed({3'b000, {(CoordW-1){1'b1}}})) begin
        cont_d[i] = {1'b0, {(CoordW-1){1'b1}}};
      end else if (csum < $signed({3'b111, {(CoordW-1){1'b0}}})) begin
        cont_d[i] = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
        cont_d[i] = csum[CoordW-1:0];
      end
      if (!mul_q.hit) begin
        cont_d[i] = '0;
      end
      nrm_d[i] = mul_q.hit ? mul_q.nrm[i] : '0;
    end
    depth_d = mul_q.hit ? mul_q.depth : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cont_q  <= cont_d;
      nrm_q   <= nrm_d;
      depth_q <= depth_d;
      hit_q   <= mul_q.hit;
    end
  end

  assign valid_o     = out_v_q;
  assign hit_o       = hit_q;
  assign normal_x_o  = nrm_q[0];
  assign normal_y_o  = nrm_q[1];
  assign normal_z_o  = nrm_q[2];
  assign contact_x_o = cont_q[0];
  assign contact_y_o = cont_q[1];
  assign contact_z_o = cont_q[2];
  assign depth_o     = depth_q;

`ifndef SYNTHESIS
  // A miss carries no normal, contact point or depth; checked on depth, normal x and contact z.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !hit_o) |-> (depth_o == '0 && normal_x_o == '0 && contact_z_o == '0))
    else $error("miss result carries non-zero fields");

  // Normal components never exceed one in magnitude; checked on the x component.
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($signed(normal_x_o) <= $signed(32'sh4000_0000) &&
                 $signed(normal_x_o) >= $signed(-32'sh4000_0000)))
    else $error("normal out of range");

  // Back-pressure is exactly a held result.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o == (valid_o && stall_i))
    else $error("stall does not follow the output stage");
`endif

endmodule

`default_nettype wire

### tb/contact_checker.sv
// Checker for the sphere contact pipeline: predicts every accepted request and
// compares each delivered result with the oldest prediction. Depends on ssc_pkg.
`timescale 1ns / 1ps

module contact_checker import ssc_pkg::*; #(
  parameter int unsigned SQRT_STEPS = 32
) (
  input  logic              clk_i,
  input  logic              valid_i,
  input  logic              stall_o,
  input  logic [CoordW-1:0] first_x_i,
  input  logic [CoordW-1:0] first_y_i,
  input  logic [CoordW-1:0] first_z_i,
  input  logic [RadW-1:0]   first_radius_i,
  input  logic [CoordW-1:0] second_x_i,
  input  logic [CoordW-1:0] second_y_i,
  input  logic [CoordW-1:0] second_z_i,
  input  logic [RadW-1:0]   second_radius_i,
  input  logic              valid_o,
  input  logic              stall_i,
  input  logic              hit_o,
  input  logic [CoordW-1:0] normal_x_o,
  input  logic [CoordW-1:0] normal_y_o,
  input  logic [CoordW-1:0] normal_z_o,
  input  logic [CoordW-1:0] contact_x_o,
  input  logic [CoordW-1:0] contact_y_o,
  input  logic [CoordW-1:0] contact_z_o,
  input  logic [CoordW-1:0] depth_o,
  output int                errors_o,
  output int                pending_o
);

  typedef struct {
    logic              hit;
    logic [CoordW-1:0] normal [3];
    logic [CoordW-1:0] contact [3];
    logic [CoordW-1:0] depth;
  } contact_t;

  contact_t expected_contacts [$];
  int       errors = 0;

  assign errors_o  = errors;
  assign pending_o = expected_contacts.size();

  // Bit-serial root of the squared distance, resolving a fixed number of bits.
  function automatic logic [RootW-1:0] centre_distance(logic [SumW-1:0] s);
    int               m, b, stop;
    logic [RootW-1:0] r, t;
    logic [SumW-1:0]  sq;
    m = -1;
    r = '0;
    for (b = 0; b < SumW; b++) if (s[b]) m = b;
    if (m < 0) return '0;
    stop = m / 2 + 1 - int'(SQRT_STEPS);
    if (stop < 0) stop = 0;
    for (b = m / 2; b >= stop; b--) begin
      t  = r | (RootW'(1) << b);
      sq = SumW'(t) * SumW'(t);
      if (sq <= s) r = t;
    end
    return r;
  endfunction

  // Works out the full contact result of one sphere pair.
  function automatic contact_t predict_contact(logic [CoordW-1:0] c1 [3],
                                               logic [CoordW-1:0] c2 [3],
                                               logic [RadW-1:0] r1,
                                               logic [RadW-1:0] r2);
    contact_t             res;
    logic signed [DiffW:0] d [3];
    logic [DiffW-1:0]     mag [3];
    logic [SumW-1:0]      s;
    logic [RootW-1:0]     len;
    logic [63:0]          rsum, q, off;
    logic signed [63:0]   c;
    s    = '0;
    rsum = 64'(r1) + 64'(r2);
    for (int i = 0; i < 3; i++) begin
      d[i]   = (DiffW+1)'(signed'(c1[i])) - (DiffW+1)'(signed'(c2[i]));
      mag[i] = d[i] < 0 ? DiffW'(-d[i]) : DiffW'(d[i]);
      s      = s + SumW'(mag[i]) * SumW'(mag[i]);
    end
    len       = centre_distance(s);
    res.hit   = 64'(len) < rsum;
    res.depth = '0;
    for (int i = 0; i < 3; i++) begin
      res.normal[i]  = '0;
      res.contact[i] = '0;
    end
    if (!res.hit) return res;
    for (int i = 0; i < 3; i++) begin
      q = '0;
      if (len != 0) begin
        q = (64'(mag[i]) << 30) / 64'(len);
        if (q > 64'd1 << 30) q = 64'd1 << 30;
      end
      off = (q * 64'(r1)) >> 30;
      c   = 64'(signed'(c1[i]));
      c   = (d[i] < 0 && q != 0) ? c + signed'(off) : c - signed'(off);
      if (c > 64'sd2147483647) c = 64'sd2147483647;
      if (c < -64'sd2147483648) c = -64'sd2147483648;
      res.normal[i]  = d[i] < 0 ? CoordW'(-q) : CoordW'(q);
      res.contact[i] = CoordW'(c);
    end
    res.depth = CoordW'(rsum - 64'(len));
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [CoordW-1:0] got,
                                 logic [CoordW-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // Record a prediction for each accepted request.
  always @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      expected_contacts.push_back(predict_contact(
          '{first_x_i, first_y_i, first_z_i}, '{second_x_i, second_y_i, second_z_i},
          first_radius_i, second_radius_i));
    end
  end

  // Compare each delivered result with the oldest prediction.
  always @(posedge clk_i) begin
    contact_t want;
    if (valid_o && !stall_i) begin
      if (expected_contacts.size() == 0) begin
        report_mismatch("unexpected result", {31'd0, hit_o}, '0);
      end else begin
        want = expected_contacts.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", {31'd0, hit_o}, {31'd0, want.hit});
        if (normal_x_o !== want.normal[0]) report_mismatch("normal_x", normal_x_o, want.normal[0]);
        if (normal_y_o !== want.normal[1]) report_mismatch("normal_y", normal_y_o, want.normal[1]);
        if (normal_z_o !== want.normal[2]) report_mismatch("normal_z", normal_z_o, want.normal[2]);
        if (contact_x_o !== want.contact[0])
          report_mismatch("contact_x", contact_x_o, want.contact[0]);
        if (contact_y_o !== want.contact[1])
          report_mismatch("contact_y", contact_y_o, want.contact[1]);
        if (contact_z_o !== want.contact[2])
          report_mismatch("contact_z", contact_z_o, want.contact[2]);
        if (depth_o !== want.depth) report_mismatch("depth", depth_o, want.depth);
      end
    end
  end

endmodule

### tb/tb.sv
// Top of the sphere contact testbench: clock, reset, request stimulus and verdict.
// Depends on ssc_pkg, the block and contact_checker.
`timescale 1ns / 1ps

module tb;
  import ssc_pkg::*;

  localparam int unsigned RandomPairs = 530;
  localparam int unsigned CycleLimit  = 400000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              valid_in = 1'b0;
  logic              stall_in;
  logic [CoordW-1:0] fx = '0, fy = '0, fz = '0, sx = '0, sy = '0, sz = '0;
  logic [RadW-1:0]   fr = '0, sr = '0;
  logic              valid_out, stall_out = 1'b0;
  logic              hit;
  logic [CoordW-1:0] nx, ny, nz, cx, cy, cz, depth;
  int                errors, pending;
  int                cycles = 0;
  bit                hold_req = 1'b0, hold_done = 1'b0;

  always #2 clk = ~clk;

  sphere_sphere_contact dut (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(valid_in), .stall_o(stall_in),
    .first_x_i(fx), .first_y_i(fy), .first_z_i(fz), .first_radius_i(fr),
    .second_x_i(sx), .second_y_i(sy), .second_z_i(sz), .second_radius_i(sr),
    .valid_o(valid_out), .stall_i(stall_out), .hit_o(hit),
    .normal_x_o(nx), .normal_y_o(ny), .normal_z_o(nz),
    .contact_x_o(cx), .contact_y_o(cy), .contact_z_o(cz), .depth_o(depth)
  );

  contact_checker u_checker (
    .clk_i(clk), .valid_i(valid_in), .stall_o(stall_in),
    .first_x_i(fx), .first_y_i(fy), .first_z_i(fz), .first_radius_i(fr),
    .second_x_i(sx), .second_y_i(sy), .second_z_i(sz), .second_radius_i(sr),
    .valid_o(valid_out), .stall_i(stall_out), .hit_o(hit),
    .normal_x_o(nx), .normal_y_o(ny), .normal_z_o(nz),
    .contact_x_o(cx), .contact_y_o(cy), .contact_z_o(cz), .depth_o(depth),
    .errors_o(errors), .pending_o(pending)
  );

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stalls: changing duty per stretch, plus one long hold-off on request.
  always @(posedge clk) begin
    int duty;
    if (hold_req && !hold_done) begin
      stall_out <= 1'b1;
      repeat (300) @(posedge clk);
      hold_done = 1'b1;
      stall_out <= 1'b0;
    end else begin
      if (cycles % 64 == 0) duty = $urandom_range(0, 3) * 25;
      stall_out <= ($urandom_range(0, 99) < duty);
    end
  end

  // Offer one request and hold it until it is accepted.
  task automatic send_pair(logic [CoordW-1:0] ax, ay, az, logic [RadW-1:0] ar,
                           logic [CoordW-1:0] bx, by, bz, logic [RadW-1:0] br);
    valid_in <= 1'b1;
    fx <= ax; fy <= ay; fz <= az; fr <= ar;
    sx <= bx; sy <= by; sz <= bz; sr <= br;
    @(posedge clk);
    while (stall_in) @(posedge clk);
  endtask

  // Burst and gap pattern of the sender.
  int burst_left = 0;
  task automatic sender_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 2) != 0) begin
        valid_in <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Random pair: mostly near contacts with small offsets, otherwise raw noise.
  task automatic send_random();
    logic [CoordW-1:0] ax, ay, az, bx, by, bz;
    logic [RadW-1:0]   ar, br;
    int                span;
    ax = $urandom; ay = $urandom; az = $urandom;
    ar = RadW'($urandom); br = RadW'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      span = $urandom_range(4, 28);
      ax = $signed(ax) >>> $urandom_range(0, 8);
      bx = ax + ($signed($urandom) >>> (32 - span));
      by = ay + ($signed($urandom) >>> (32 - span));
      bz = az + ($signed($urandom) >>> (32 - span));
      ar = RadW'($urandom & ((32'd1 << (span + 1)) - 1));
      br = RadW'($urandom & ((32'd1 << (span + 1)) - 1));
    end else begin
      bx = $urandom; by = $urandom; bz = $urandom;
    end
    send_pair(ax, ay, az, ar, bx, by, bz, br);
  endtask

  localparam logic [CoordW-1:0] MaxC = 32'h7fff_ffff;
  localparam logic [CoordW-1:0] MinC = 32'h8000_0000;
  localparam logic [RadW-1:0]   MaxR = 31'h7fff_ffff;
  localparam logic [CoordW-1:0] One  = 32'h0001_0000;
  localparam logic [RadW-1:0]   OneR = 31'h0001_0000;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pairs: coincident centres, zero radii, extreme coordinates.
    send_pair('0, '0, '0, '0, '0, '0, '0, '0);
    send_pair(One, One, One, OneR, One, One, One, '0);
    send_pair(MaxC, MinC, MaxC, MaxR, MaxC, MinC, MaxC, MaxR);
    send_pair(MaxC, MaxC, MaxC, MaxR, MinC, MinC, MinC, MaxR);
    send_pair(MinC, MinC, MinC, MaxR, MaxC, MaxC, MaxC, MaxR);
    send_pair(MaxC, '0, '0, MaxR, MinC, '0, '0, MaxR);
    send_pair(MinC, '0, '0, MaxR, MaxC, '0, '0, '0);
    send_pair('0, MaxC, '0, MaxR, '0, '0, '0, MaxR);
    send_pair('0, '0, MinC, MaxR, '0, '0, '0, '0);
    send_pair(MaxC, MaxC, MaxC, MaxR, '0, '0, '0, '0);
    send_pair(2 * One, '0, '0, OneR, '0, '0, '0, OneR);
    send_pair(2 * One, '0, '0, OneR + 31'd1, '0, '0, '0, OneR);
    send_pair('0, -2 * One, '0, OneR, '0, '0, '0, 31'd2 * OneR);
    send_pair(3 * One, 4 * One, '0, 31'd2 * OneR, '0, '0, '0, 31'd4 * OneR);
    send_pair(-3 * One, '0, -4 * One, 31'd6 * OneR, '0, '0, '0, '0);
    send_pair(32'd1, '0, '0, 31'd1, '0, '0, '0, 31'd1);
    send_pair(32'd1, 32'd1, 32'd1, '0, '0, '0, '0, 31'd2);
    send_pair(MaxC, MaxC, '0, MaxR, MaxC - 1, MaxC, '0, 31'd5);
    send_pair(MinC, MinC, '0, MaxR, MinC + 1, MinC, '0, 31'd5);
    send_pair(MaxC, '0, '0, MaxR, MaxC - 32'd100, '0, '0, MaxR);
    send_pair(MinC, '0, '0, MaxR, MinC + 32'd100, '0, '0, MaxR);

    for (int n = 0; n < RandomPairs; n++) begin
      if (n == 150) hold_req = 1'b1;
      if (n == 300) begin
        valid_in <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_random();
      sender_gap();
    end
    valid_in <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sphere_sphere_contact.f
rtl/ssc_pkg.sv
rtl/ssc_front.sv
rtl/ssc_sqrt_stage.sv
rtl/ssc_div_stage.sv
rtl/sphere_sphere_contact.sv
tb/contact_checker.sv
tb/tb.sv
